// File: rtl/sv39pte_pkg.sv
// ----------------------------------------------------------------------------
// sv39pte_pkg
// Shared types and codes of the Sv39 page table engine: payload words,
// status and action codes, sequencer states and memory command.
// ----------------------------------------------------------------------------
package sv39pte_pkg;

  localparam int TABLE_PAGES_DEF   = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int VPN_W             = 9;
  localparam int PPN_W             = 44;
  localparam int FLAGS_W           = 10;
  localparam int ENTRY_W           = PPN_W + FLAGS_W;
  localparam int PADDR_W           = 4;
  localparam int PDATA_W           = 64;

  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_WALK  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_REMAP   = 3'd1;
  localparam logic [2:0] ST_NOMAP   = 3'd2;
  localparam logic [2:0] ST_BADSIZE = 3'd3;
  localparam logic [2:0] ST_NOPAGES = 3'd4;

  localparam logic [1:0] SZ_4K  = 2'd0;
  localparam logic [1:0] SZ_2M  = 2'd1;
  localparam logic [1:0] SZ_1G  = 2'd2;
  localparam logic [1:0] SZ_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [38:0]        virt_addr;
    logic [PPN_W-1:0]   phys_page;
    logic [FLAGS_W-1:0] leaf_flags;
    logic [1:0]         size_code;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [PPN_W-1:0]   found_page;
    logic [FLAGS_W-1:0] found_flags;
    logic [1:0]         found_size;
  } rsp_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_L2,
    S_L1,
    S_L0,
    S_WRITE,
    S_RESP
  } state_t;

endpackage

// File: rtl/sv39pte_mem.sv
// ----------------------------------------------------------------------------
// sv39pte_mem
// Single-port table store, one entry per cycle, registered read data.
// ----------------------------------------------------------------------------
module sv39pte_mem #(
  parameter int DEPTH = sv39pte_pkg::TABLE_PAGES_DEF * sv39pte_pkg::ENTRIES_PER_TABLE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  sv39pte_pkg::mem_cmd_t            cmd,
  input  logic [AW-1:0]                    addr,
  input  logic [sv39pte_pkg::ENTRY_W-1:0]  wdata,
  output logic [sv39pte_pkg::ENTRY_W-1:0]  rdata
);

  logic [sv39pte_pkg::ENTRY_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      store[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= store[addr];
    end
  end

endmodule

// File: rtl/sv39pte_ctrl.sv
// ----------------------------------------------------------------------------
// sv39pte_ctrl
// Walk sequencer: clears the store after reset, reads one level per cycle,
// decides, drains queued writes and hands the result word to the output.
// ----------------------------------------------------------------------------
module sv39pte_ctrl #(
  parameter int TABLE_PAGES = sv39pte_pkg::TABLE_PAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  sv39pte_pkg::req_t                  req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output sv39pte_pkg::rsp_t                  rsp,
  input  logic [sv39pte_pkg::PPN_W-1:0]      base,
  output sv39pte_pkg::mem_cmd_t              mem_cmd,
  output logic [$clog2(TABLE_PAGES)+sv39pte_pkg::VPN_W-1:0] mem_addr,
  output logic [sv39pte_pkg::ENTRY_W-1:0]    mem_wdata,
  input  logic [sv39pte_pkg::ENTRY_W-1:0]    mem_rdata
);

  localparam int PW    = $clog2(TABLE_PAGES);
  localparam int AW    = PW + sv39pte_pkg::VPN_W;
  localparam int CW    = $clog2(TABLE_PAGES + 1);
  localparam int DEPTH = TABLE_PAGES * sv39pte_pkg::ENTRIES_PER_TABLE;
  localparam int EW    = sv39pte_pkg::ENTRY_W;
  localparam int NW    = sv39pte_pkg::PPN_W;

  sv39pte_pkg::state_t state, state_next;

  logic [AW-1:0]  clr_cnt;
  logic [CW-1:0]  pages_used;
  logic [1:0]     w_idx;
  logic [1:0]     w_num;
  logic [AW-1:0]  w_addr [3];
  logic [EW-1:0]  w_data [3];
  logic [PW-1:0]  cur_page;

  logic [1:0]     act;
  logic [1:0]     sz;
  logic [8:0]     v2, v1, v0;
  logic [EW-1:0]  leaf;
  logic [2:0]     res_status;
  logic [EW-1:0]  res_entry;
  logic [1:0]     res_size;

  // decision of the current level
  logic           dec_read;
  logic [AW-1:0]  dec_rd_addr;
  logic [PW-1:0]  dec_rd_page;
  logic [2:0]     dec_status;
  logic [1:0]     dec_nw;
  logic [AW-1:0]  dec_w_addr [3];
  logic [EW-1:0]  dec_w_data [3];
  logic [1:0]     dec_take;
  logic           dec_found;
  logic [1:0]     dec_fsize;

  logic           e_valid, e_ptr, fol_ok;
  logic [NW-1:0]  fol_idx;
  logic [PW-1:0]  fol_page, pu_page, pu_page1;
  logic [CW-1:0]  left;
  logic [EW-1:0]  ptr_a, ptr_b;
  logic           is_map;
  logic           accept;

  assign e_valid  = mem_rdata[0];
  assign e_ptr    = (mem_rdata[3:0] == 4'b0001);
  assign fol_idx  = mem_rdata[EW-1:10] - base;
  assign fol_ok   = (fol_idx < NW'(pages_used));
  assign fol_page = fol_idx[PW-1:0];
  assign left     = CW'(TABLE_PAGES) - pages_used;
  assign pu_page  = pages_used[PW-1:0];
  assign pu_page1 = pages_used[PW-1:0] + PW'(1);
  assign ptr_a    = {base + NW'(pu_page), 10'h001};
  assign ptr_b    = {base + NW'(pu_page1), 10'h001};
  assign is_map   = (act == sv39pte_pkg::ACT_MAP);
  assign accept   = req_valid && req_ready;

  always_comb begin
    dec_read    = 1'b0;
    dec_rd_addr = '0;
    dec_rd_page = fol_page;
    dec_status  = sv39pte_pkg::ST_OK;
    dec_nw      = 2'd0;
    dec_take    = 2'd0;
    dec_found   = 1'b0;
    dec_fsize   = sv39pte_pkg::SZ_4K;
    for (int i = 0; i < 3; i++) begin
      dec_w_addr[i] = '0;
      dec_w_data[i] = '0;
    end
    case (state)
      sv39pte_pkg::S_L2: begin
        if (is_map) begin
          if (sz == sv39pte_pkg::SZ_1G) begin
            if (e_valid) begin
              dec_status = sv39pte_pkg::ST_REMAP;
            end else begin
              dec_nw = 2'd1;
              dec_w_addr[0] = {PW'(0), v2};
              dec_w_data[0] = leaf;
            end
          end else if (!e_valid) begin
            if (left < ((sz == sv39pte_pkg::SZ_4K) ? CW'(2) : CW'(1))) begin
              dec_status = sv39pte_pkg::ST_NOPAGES;
            end else begin
              dec_w_addr[0] = {PW'(0), v2};
              dec_w_data[0] = ptr_a;
              dec_w_addr[1] = {pu_page, v1};
              if (sz == sv39pte_pkg::SZ_2M) begin
                dec_nw = 2'd2;
                dec_take = 2'd1;
                dec_w_data[1] = leaf;
              end else begin
                dec_nw = 2'd3;
                dec_take = 2'd2;
                dec_w_data[1] = ptr_b;
                dec_w_addr[2] = {pu_page1, v0};
                dec_w_data[2] = leaf;
              end
            end
          end else if (!e_ptr || !fol_ok) begin
            dec_status = sv39pte_pkg::ST_REMAP;
          end else begin
            dec_read = 1'b1;
            dec_rd_addr = {fol_page, v1};
          end
        end else begin
          if (!e_valid) begin
            dec_status = sv39pte_pkg::ST_NOMAP;
          end else if (!e_ptr) begin
            dec_found = 1'b1;
            dec_fsize = sv39pte_pkg::SZ_1G;
            dec_w_addr[0] = {PW'(0), v2};
            dec_nw = (act == sv39pte_pkg::ACT_UNMAP) ? 2'd1 : 2'd0;
          end else if (!fol_ok) begin
            dec_status = sv39pte_pkg::ST_NOMAP;
          end else begin
            dec_read = 1'b1;
            dec_rd_addr = {fol_page, v1};
          end
        end
      end
      sv39pte_pkg::S_L1: begin
        if (is_map) begin
          if (sz == sv39pte_pkg::SZ_2M) begin
            if (e_valid) begin
              dec_status = sv39pte_pkg::ST_REMAP;
            end else begin
              dec_nw = 2'd1;
              dec_w_addr[0] = {cur_page, v1};
              dec_w_data[0] = leaf;
            end
          end else if (!e_valid) begin
            if (left < CW'(1)) begin
              dec_status = sv39pte_pkg::ST_NOPAGES;
            end else begin
              dec_nw = 2'd2;
              dec_take = 2'd1;
              dec_w_addr[0] = {pu_page, v0};
              dec_w_data[0] = leaf;
              dec_w_addr[1] = {cur_page, v1};
              dec_w_data[1] = ptr_a;
            end
          end else if (!e_ptr || !fol_ok) begin
            dec_status = sv39pte_pkg::ST_REMAP;
          end else begin
            dec_read = 1'b1;
            dec_rd_addr = {fol_page, v0};
          end
        end else begin
          if (!e_valid) begin
            dec_status = sv39pte_pkg::ST_NOMAP;
          end else if (!e_ptr) begin
            dec_found = 1'b1;
            dec_fsize = sv39pte_pkg::SZ_2M;
            dec_w_addr[0] = {cur_page, v1};
            dec_nw = (act == sv39pte_pkg::ACT_UNMAP) ? 2'd1 : 2'd0;
          end else if (!fol_ok) begin
            dec_status = sv39pte_pkg::ST_NOMAP;
          end else begin
            dec_read = 1'b1;
            dec_rd_addr = {fol_page, v0};
          end
        end
      end
      sv39pte_pkg::S_L0: begin
        if (is_map) begin
          if (e_valid) begin
            dec_status = sv39pte_pkg::ST_REMAP;
          end else begin
            dec_nw = 2'd1;
            dec_w_addr[0] = {cur_page, v0};
            dec_w_data[0] = leaf;
          end
        end else begin
          if (!e_valid) begin
            dec_status = sv39pte_pkg::ST_NOMAP;
          end else begin
            dec_found = 1'b1;
            dec_fsize = sv39pte_pkg::SZ_4K;
            dec_w_addr[0] = {cur_page, v0};
            dec_nw = (act == sv39pte_pkg::ACT_UNMAP) ? 2'd1 : 2'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sv39pte_pkg::S_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) state_next = sv39pte_pkg::S_IDLE;
      end
      sv39pte_pkg::S_IDLE: begin
        if (accept) begin
          if ((req.action == sv39pte_pkg::ACT_MAP && req.size_code == sv39pte_pkg::SZ_BAD)
              || req.action == sv39pte_pkg::ACT_NOP) begin
            state_next = sv39pte_pkg::S_RESP;
          end else begin
            state_next = sv39pte_pkg::S_L2;
          end
        end
      end
      sv39pte_pkg::S_L2, sv39pte_pkg::S_L1, sv39pte_pkg::S_L0: begin
        if (dec_read) begin
          state_next = (state == sv39pte_pkg::S_L2) ? sv39pte_pkg::S_L1 : sv39pte_pkg::S_L0;
        end else if (dec_nw != 2'd0) begin
          state_next = sv39pte_pkg::S_WRITE;
        end else begin
          state_next = sv39pte_pkg::S_RESP;
        end
      end
      sv39pte_pkg::S_WRITE: begin
        if (w_idx == w_num - 2'd1) state_next = sv39pte_pkg::S_RESP;
      end
      sv39pte_pkg::S_RESP: begin
        if (!rsp_valid || rsp_ready) state_next = sv39pte_pkg::S_IDLE;
      end
      default: state_next = sv39pte_pkg::S_CLEAR;
    endcase
  end

  // memory and handshake outputs
  always_comb begin
    mem_cmd   = '0;
    mem_addr  = '0;
    mem_wdata = '0;
    req_ready = 1'b0;
    unique case (state)
      sv39pte_pkg::S_CLEAR: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = clr_cnt;
      end
      sv39pte_pkg::S_IDLE: begin
        req_ready  = 1'b1;
        mem_cmd.rd = 1'b1;
        mem_addr   = {PW'(0), req.virt_addr[38:30]};
      end
      sv39pte_pkg::S_L2, sv39pte_pkg::S_L1, sv39pte_pkg::S_L0: begin
        mem_cmd.rd = dec_read;
        mem_addr   = dec_rd_addr;
      end
      sv39pte_pkg::S_WRITE: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = w_addr[w_idx];
        mem_wdata  = w_data[w_idx];
      end
      sv39pte_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sv39pte_pkg::S_CLEAR;
      clr_cnt    <= '0;
      pages_used <= CW'(1);
      w_idx      <= '0;
      w_num      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sv39pte_pkg::S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (state == sv39pte_pkg::S_L2 || state == sv39pte_pkg::S_L1
          || state == sv39pte_pkg::S_L0) begin
        pages_used <= pages_used + CW'(dec_take);
        w_num      <= dec_nw;
        w_idx      <= '0;
      end
      if (state == sv39pte_pkg::S_WRITE) w_idx <= w_idx + 2'd1;
      if (state == sv39pte_pkg::S_RESP && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload: held item, decision results, output word
  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= req.action;
      sz   <= req.size_code;
      v2   <= req.virt_addr[38:30];
      v1   <= req.virt_addr[29:21];
      v0   <= req.virt_addr[20:12];
      leaf <= {req.phys_page, req.leaf_flags};
      res_entry <= '0;
      res_size  <= sv39pte_pkg::SZ_4K;
      res_status <= (req.action == sv39pte_pkg::ACT_MAP && req.size_code == sv39pte_pkg::SZ_BAD)
                    ? sv39pte_pkg::ST_BADSIZE : sv39pte_pkg::ST_OK;
    end
    if (state == sv39pte_pkg::S_L2 || state == sv39pte_pkg::S_L1
        || state == sv39pte_pkg::S_L0) begin
      cur_page   <= dec_rd_page;
      res_status <= dec_status;
      if (dec_found && act == sv39pte_pkg::ACT_WALK) begin
        res_entry <= mem_rdata;
        res_size  <= dec_fsize;
      end
      for (int i = 0; i < 3; i++) begin
        w_addr[i] <= dec_w_addr[i];
        w_data[i] <= dec_w_data[i];
      end
    end
    if (state == sv39pte_pkg::S_RESP && (!rsp_valid || rsp_ready)) begin
      rsp.status      <= res_status;
      rsp.found_page  <= res_entry[EW-1:10];
      rsp.found_flags <= res_entry[9:0];
      rsp.found_size  <= res_size;
    end
  end

endmodule

// File: rtl/sv39_page_table_engine.sv
// ----------------------------------------------------------------------------
// sv39_page_table_engine
// Three-level Sv39 page table kept in an on-chip table store; maps, unmaps
// and walks one virtual address per request word.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one request word: action
//   (map, unmap, walk, no-op), virtual address, physical page, leaf flags, size.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one word per
//   request: status, and for a successful walk the leaf page, flags, size.
//   APB port holds table_base_ppn at byte address 0 (64-bit data); write it
//   only while no request is in flight.
// Sequence: an accept step that reads the root entry, one step per table
//   level read, one per table write, one response step that loads the word
//   onto rsp. A bad size or a no-op action goes straight from accept to the
//   response step. A 4K map into an empty root slot reads once and writes
//   three entries; a map or unmap at level 0 reads three levels and writes
//   once. The table store is single-port, one read or one write per cycle.
// Reset: rst is synchronous. Afterwards the engine sweeps the table store,
//   all TABLE_PAGES*512 entries (32768 by default), to zero one entry a
//   cycle with req_ready low; APB writes are taken throughout. The pool
//   restarts with only the root page in use.
// Stall: a finished word waits in the output register; a new request is
//   taken meanwhile and its result is held until rsp_ready drains the first.
// ----------------------------------------------------------------------------
module sv39_page_table_engine #(
  parameter int TABLE_PAGES = sv39pte_pkg::TABLE_PAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  sv39pte_pkg::req_t                   req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output sv39pte_pkg::rsp_t                   rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sv39pte_pkg::PADDR_W-1:0]     paddr,
  input  logic [sv39pte_pkg::PDATA_W-1:0]     pwdata,
  output logic [sv39pte_pkg::PDATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int DEPTH = TABLE_PAGES * sv39pte_pkg::ENTRIES_PER_TABLE;
  localparam int AW    = $clog2(TABLE_PAGES) + sv39pte_pkg::VPN_W;

  logic [sv39pte_pkg::PPN_W-1:0]   table_base_ppn;
  sv39pte_pkg::mem_cmd_t           mem_cmd;
  logic [AW-1:0]                   mem_addr;
  logic [sv39pte_pkg::ENTRY_W-1:0] mem_wdata;
  logic [sv39pte_pkg::ENTRY_W-1:0] mem_rdata;
  logic                            base_sel;

  // Register 0 decodes from paddr[3]; anything at 8 and up is beyond the map.
  assign base_sel = (paddr[3] == 1'b0);
  assign pready   = 1'b1;
  assign prdata   = base_sel ? sv39pte_pkg::PDATA_W'(table_base_ppn) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base_ppn <= '0;
    end else if (psel && penable && pwrite && base_sel) begin
      table_base_ppn <= pwdata[sv39pte_pkg::PPN_W-1:0];
    end
  end

  sv39pte_ctrl #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .base      (table_base_ppn),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  sv39pte_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// File: rtl/sv39pte_checker.sv
// ----------------------------------------------------------------------------
// sv39pte_checker
// Port-level checks of the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
module sv39pte_checker (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input sv39pte_pkg::rsp_t rsp
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response word present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= sv39pte_pkg::ST_NOPAGES)
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != sv39pte_pkg::ST_OK |->
      rsp.found_page == '0 && rsp.found_flags == '0 && rsp.found_size == '0)
    else $error("failed request returned leaf data");

endmodule

bind sv39_page_table_engine sv39pte_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
